FILE: hdl/apq_pkg.sv
// shared types, constants and the entry compare for the array priority queue
package apq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned PID_W        = 4;
  localparam int unsigned TIME_W       = 15;
  localparam int unsigned OCC_W        = 5;

  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_POP  = 2'd1;
  localparam logic [1:0] MODE_PEEK = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [PID_W-1:0]  in_process_id;
    logic [TIME_W-1:0] in_time;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [PID_W-1:0]  out_process_id;
    logic [TIME_W-1:0] out_time;
    logic              overflow;
    logic [OCC_W-1:0]  occupancy;
  } out_item_t;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [TIME_W-1:0] tstamp;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE,
    ST_RESP
  } state_e;

  // larger timestamp wins, smaller process id breaks a tie
  function automatic logic beats(entry_t a, entry_t b);
    logic res;
    if (a.tstamp != b.tstamp) begin
      res = (a.tstamp > b.tstamp);
    end else begin
      res = (a.pid < b.pid);
    end
    return res;
  endfunction

endpackage

FILE: hdl/apq_store.sv
// entry memory: one write port, one read port with registered read data
module apq_store #(
  parameter int unsigned Depth = apq_pkg::CAPACITY_DEF,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  apq_pkg::entry_t  wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output apq_pkg::entry_t  rdata_o
);
  import apq_pkg::*;

  entry_t mem [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/array_priority_queue.sv
// array priority queue: push / pop / peek over an unsorted entry memory
// push, empty pop/peek and unused modes go straight to the response state; pop/peek on a
// non-empty queue scan every held entry, and a pop then moves the last entry into the hole
// a new item is taken only once the last result is out (busy_o low); the scan runs through
// the single memory read port and one shared comparator, one entry a cycle
// reset: entry count cleared, memory contents left as they are; results cannot be stalled
module array_priority_queue #(
  parameter int unsigned Capacity = apq_pkg::CAPACITY_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  apq_pkg::in_item_t  item_i,
  output logic               result_valid_o,
  output apq_pkg::out_item_t result_o
);
  import apq_pkg::*;

  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(Capacity);

  state_e state_q, state_d;

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] issue_q, issue_d;
  logic            rvld_q, rvld_d;
  logic [IdxW-1:0] ridx_q, ridx_d;
  logic [IdxW-1:0] best_idx_q, best_idx_d;
  entry_t          best_q, best_d;
  logic [1:0]      mode_q, mode_d;
  logic            res_found_q, res_found_d;
  logic            res_ovf_q, res_ovf_d;
  entry_t          res_ent_q, res_ent_d;

  logic            accept;
  logic            full;
  logic            seek;
  logic [CntW-1:0] cnt_m1;
  logic            scan_done;
  logic            win;
  entry_t          win_ent;
  logic [IdxW-1:0] win_idx;
  logic [CntW+OCC_W-1:0] occ_ext;

  logic            we;
  logic [IdxW-1:0] waddr;
  entry_t          wdata;
  logic            re;
  logic [IdxW-1:0] raddr;
  entry_t          rdata;

  apq_store #(
    .Depth (Capacity)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign busy_o    = (state_q != ST_IDLE);
  assign accept    = start_i && !busy_o;
  assign full      = (count_q == CapCnt);
  assign seek      = ((item_i.mode == MODE_POP) || (item_i.mode == MODE_PEEK))
                     && (count_q != '0);
  assign cnt_m1    = count_q - CntW'(1);
  assign scan_done = rvld_q && (ridx_q == cnt_m1[IdxW-1:0]);

  // shared comparator: running best against the entry just read
  assign win     = (ridx_q == '0) || beats(rdata, best_q);
  assign win_ent = win ? rdata : best_q;
  assign win_idx = win ? ridx_q : best_idx_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = seek ? ST_SCAN : ST_RESP;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = (mode_q == MODE_POP) ? ST_MOVE : ST_RESP;
        end
      end
      ST_MOVE: state_d = ST_RESP;
      ST_RESP: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    count_d     = count_q;
    issue_d     = issue_q;
    rvld_d      = 1'b0;
    ridx_d      = ridx_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    mode_d      = mode_q;
    res_found_d = res_found_q;
    res_ovf_d   = res_ovf_q;
    res_ent_d   = res_ent_q;
    we          = 1'b0;
    waddr       = count_q[IdxW-1:0];
    wdata       = '{pid: item_i.in_process_id, tstamp: item_i.in_time};
    re          = 1'b0;
    raddr       = issue_q[IdxW-1:0];
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mode_d      = item_i.mode;
          issue_d     = '0;
          res_found_d = 1'b0;
          res_ent_d   = '0;
          res_ovf_d   = (item_i.mode == MODE_PUSH) && full;
          if ((item_i.mode == MODE_PUSH) && !full) begin
            we      = 1'b1;
            count_d = count_q + CntW'(1);
          end
        end
      end
      ST_SCAN: begin
        if (issue_q < count_q) begin
          re      = 1'b1;
          rvld_d  = 1'b1;
          ridx_d  = issue_q[IdxW-1:0];
          issue_d = issue_q + CntW'(1);
        end
        if (rvld_q) begin
          best_d     = win_ent;
          best_idx_d = win_idx;
        end
        if (scan_done) begin
          res_found_d = 1'b1;
          res_ent_d   = win_ent;
          // fetch the last entry to fill the hole on a pop
          re    = (mode_q == MODE_POP);
          raddr = cnt_m1[IdxW-1:0];
        end
      end
      ST_MOVE: begin
        we      = 1'b1;
        waddr   = best_idx_q;
        wdata   = rdata;
        count_d = cnt_m1;
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rvld_q  <= rvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    issue_q     <= issue_d;
    ridx_q      <= ridx_d;
    best_idx_q  <= best_idx_d;
    best_q      <= best_d;
    mode_q      <= mode_d;
    res_found_q <= res_found_d;
    res_ovf_q   <= res_ovf_d;
    res_ent_q   <= res_ent_d;
  end

  assign occ_ext = {{OCC_W{1'b0}}, count_q};

  assign result_valid_o          = (state_q == ST_RESP);
  assign result_o.found          = res_found_q;
  assign result_o.out_process_id = res_ent_q.pid;
  assign result_o.out_time       = res_ent_q.tstamp;
  assign result_o.overflow       = res_ovf_q;
  assign result_o.occupancy      = occ_ext[OCC_W-1:0];

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCnt)
    else $error("entry count above capacity");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (item_i.mode == MODE_PUSH) && !full |=> count_q == $past(count_q) + CntW'(1))
    else $error("accepted push did not grow the count");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    re |-> CntW'(raddr) < count_q)
    else $error("memory read beyond held entries");

  a_result_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(result_o.found && result_o.overflow))
    else $error("result both found and overflow");

  a_resp_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !busy_o)
    else $error("block still busy after delivering a result");

endmodule

FILE: tb/array_priority_queue_test.sv
// self-checking testbench for the array priority queue: directed and random push/pop/peek traffic
module array_priority_queue_test;
  import apq_pkg::*;

  localparam int unsigned CAP = CAPACITY_DEF;
  localparam logic [1:0] MODE_NONE = 2'd3;   // unused operation code
  localparam int unsigned ITEMS_PER_PHASE = 633;
  localparam int unsigned RUN_LEN = 40;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  class pq_shadow;
    entry_t      slots[CAP];
    int unsigned held;
    out_item_t   expected_q[$];
    int unsigned mismatches;

    function new();
      held = 0;
      mismatches = 0;
    endfunction

    // on a full tie the lower slot stays the winner
    function bit outranks(entry_t a, entry_t b);
      return {a.tstamp, ~a.pid} > {b.tstamp, ~b.pid};
    endfunction

    function void note_request(in_item_t req);
      out_item_t   res;
      int unsigned best;
      res = '0;
      case (req.mode)
        MODE_PUSH: begin
          if (held >= CAP) begin
            res.overflow = 1'b1;
          end else begin
            slots[held].pid    = req.in_process_id;
            slots[held].tstamp = req.in_time;
            held++;
          end
        end
        MODE_POP, MODE_PEEK: begin
          if (held > 0) begin
            best = 0;
            for (int unsigned i = 1; i < held; i++) begin
              if (outranks(slots[i], slots[best])) best = i;
            end
            res.found          = 1'b1;
            res.out_process_id = slots[best].pid;
            res.out_time       = slots[best].tstamp;
            if (req.mode == MODE_POP) begin
              slots[best] = slots[held-1];
              held--;
            end
          end
        end
        default: ;
      endcase
      res.occupancy = OCC_W'(held);
      expected_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_response(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %p", $time, got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("found", 32'(want.found), 32'(got.found));
      compare_field("out_process_id", 32'(want.out_process_id), 32'(got.out_process_id));
      compare_field("out_time", 32'(want.out_time), 32'(got.out_time));
      compare_field("overflow", 32'(want.overflow), 32'(got.overflow));
      compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  logic      busy_o;
  in_item_t  item_i;
  logic      result_valid_o;
  out_item_t result_o;

  pq_shadow    shadow;
  int unsigned xfer_count;
  int unsigned quiet_cycles;

  logic [PID_W-1:0]  fill_pid  [16] = '{4'd15, 4'd0, 4'd0, 4'd5, 4'd0, 4'd3, 4'd9, 4'd12,
                                       4'd1, 4'd7, 4'd14, 4'd2, 4'd10, 4'd6, 4'd11, 4'd8};
  logic [TIME_W-1:0] fill_time [16] = '{15'h7fff, 15'h0000, 15'h7fff, 15'h7fff, 15'h7fff,
                                       15'h2aaa, 15'h5555, 15'd100, 15'd100, 15'h0000,
                                       15'h0001, 15'h4000, 15'h3fff, 15'd7, 15'd7, 15'h7ffe};

  array_priority_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        shadow.note_request(item_i);
        xfer_count++;
      end
      if (result_valid_o) shadow.check_response(result_o);
      if ((start_i && !busy_o) || result_valid_o) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic in_item_t make_req(logic [1:0] mode, logic [PID_W-1:0] pid,
                                        logic [TIME_W-1:0] tstamp);
    in_item_t it;
    it.mode          = mode;
    it.in_process_id = pid;
    it.in_time       = tstamp;
    return it;
  endfunction

  // timestamps lean toward a few small values and the extremes so ties are common
  function automatic in_item_t random_req(int unsigned push_pct);
    in_item_t    it;
    int unsigned roll;
    it.in_process_id = PID_W'($urandom);
    roll = $urandom_range(99);
    if (roll < 30) begin
      it.in_time = TIME_W'($urandom_range(3));
    end else if (roll < 40) begin
      it.in_time = $urandom_range(1) ? '1 : '0;
    end else begin
      it.in_time = TIME_W'($urandom);
    end
    roll = $urandom_range(99);
    if (roll < 3) begin
      it.mode = MODE_NONE;
    end else if (roll < 3 + push_pct) begin
      it.mode = MODE_PUSH;
    end else if ($urandom_range(2) != 0) begin
      it.mode = MODE_POP;
    end else begin
      it.mode = MODE_PEEK;
    end
    return it;
  endfunction

  // start stays high from one transfer to the next unless a gap is inserted
  task automatic send_req(input in_item_t it);
    int unsigned target;
    target = xfer_count + 1;
    start_i <= 1'b1;
    item_i  <= it;
    do @(negedge clk_i); while (xfer_count < target);
  endtask

  task automatic sender_gap(input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  initial begin
    int unsigned idle_pct[3];
    int unsigned push_pct;
    shadow       = new();
    xfer_count   = 0;
    quiet_cycles = 0;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    item_i       = '0;
    idle_pct     = '{11, 87, 0};
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // empty queue and the unused code
    send_req(make_req(MODE_PEEK, 4'hf, 15'h7fff));
    send_req(make_req(MODE_POP, 4'h0, 15'h0000));
    send_req(make_req(MODE_NONE, 4'ha, 15'h5555));
    // fill to capacity with timestamp ties, a duplicate entry and the field extremes
    for (int i = 0; i < 16; i++) begin
      sender_gap(idle_pct[0]);
      send_req(make_req(MODE_PUSH, fill_pid[i], fill_time[i]));
    end
    send_req(make_req(MODE_PUSH, 4'hf, 15'h7fff));
    send_req(make_req(MODE_NONE, 4'h5, 15'h2aaa));
    send_req(make_req(MODE_PEEK, 4'h0, 15'h0000));
    repeat (3) send_req(make_req(MODE_POP, 4'h0, 15'h0000));

    push_pct = 50;
    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // runs of push-heavy or pop-heavy traffic sweep the fill level end to end
        if (n % RUN_LEN == 0) begin
          case ($urandom_range(2))
            0: push_pct = 25;
            1: push_pct = 50;
            default: push_pct = 75;
          endcase
        end
        sender_gap(idle_pct[ph]);
        send_req(random_req(push_pct));
      end
    end
    start_i <= 1'b0;

    while (shadow.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/apq_pkg.sv
hdl/apq_store.sv
hdl/array_priority_queue.sv
tb/array_priority_queue_test.sv
